[sv/fftc_pkg.sv]
// fftc_pkg: shared constants, types and functions of the radix-2 fft core
// holds the q1.15 twiddle table builder, command codes and state encodings
// depends on nothing
package fftc_pkg;

  localparam int MAX_LOG2_POINTS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int WORD_BITS       = 28;
  localparam int AW              = MAX_LOG2_POINTS;
  localparam int FULL_N          = 1 << MAX_LOG2_POINTS;
  localparam int TW_DEPTH        = (FULL_N / 2) > 0 ? (FULL_N / 2) : 1;
  localparam int TW_AW           = (TW_DEPTH > 1) ? $clog2(TW_DEPTH) : 1;
  localparam int LOG_W           = $clog2(MAX_LOG2_POINTS + 1);
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 4;
  localparam int TW_BITS         = 16;
  localparam int PROD_BITS       = WORD_BITS + TW_BITS;
  localparam int T_BITS          = WORD_BITS + 3;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  // taylor term divisors: (2i)(2i+1) for sine, (2i-1)(2i) for cosine
  localparam longint unsigned SIN_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};
  localparam longint unsigned COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
                                              64'd182};

  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_POINTS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE = 1'b1;
  localparam logic                 OPC_LOAD = 1'b0;
  localparam logic                 OPC_READ = 1'b1;

  typedef logic signed [TW_BITS-1:0] tw_tab_t [TW_DEPTH];
  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDP, ST_RDK, ST_MUL, ST_SUM, ST_WRK, ST_WRP, ST_SC_RD, ST_SC_WR
  } st_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_READ, OP_RDP, OP_RDK, OP_MUL, OP_SUM, OP_WRK, OP_WRP,
    OP_SC_RD, OP_SC_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [LOG_W-1:0] l;
    logic [LOG_W-1:0] stage;
    logic [AW-1:0]    idx;
    logic             inverse;
    logic             done;
  } dp_cmd_t;

  function automatic logic signed [TW_BITS-1:0] to_q15(input longint v);
    longint r;
    r = (v < 0) ? 64'sd0 : v;
    r = (r + (64'sd1 <<< 14)) >>> 15;
    if (r > 32767) r = 32767;
    return TW_BITS'(r);
  endfunction

  // fixed-point taylor series in q30, one quadrant folded by symmetry
  function automatic tw_tab_t build_tw(input bit want_sin);
    tw_tab_t tab;
    longint unsigned kk, x, term;
    longint s, c;
    logic signed [TW_BITS-1:0] cq;
    bit neg;
    for (int k = 0; k < TW_DEPTH; k++) begin
      kk  = longint'(k);
      neg = 1'b0;
      if (4 * k > FULL_N) begin
        kk  = longint'(TW_DEPTH - k);
        neg = 1'b1;
      end
      x    = (2 * PI_Q30 * kk + (64'd1 << (MAX_LOG2_POINTS - 1))) >> MAX_LOG2_POINTS;
      term = x;
      s    = longint'(x);
      for (int i = 1; i <= 6; i++) begin
        term = ((((term * x) >> 30) * x) >> 30) / SIN_DIV[i-1];
        s    = i[0] ? s - longint'(term) : s + longint'(term);
      end
      term = ONE_Q30;
      c    = longint'(ONE_Q30);
      for (int i = 1; i <= 7; i++) begin
        term = ((((term * x) >> 30) * x) >> 30) / COS_DIV[i-1];
        c    = i[0] ? c - longint'(term) : c + longint'(term);
      end
      cq = to_q15(c);
      if (want_sin) tab[k] = to_q15(s);
      else          tab[k] = neg ? -cq : cq;
    end
    return tab;
  endfunction

  localparam tw_tab_t TW_COS = build_tw(1'b0);
  localparam tw_tab_t TW_SIN = build_tw(1'b1);

  function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v,
                                            input logic [LOG_W-1:0] l);
    logic [AW-1:0] r;
    for (int i = 0; i < AW; i++) r[i] = v[AW-1-i];
    return r >> (LOG_W'(AW) - l);
  endfunction

  function automatic word_t sat_word(input logic signed [T_BITS:0] v);
    if (v > $signed((T_BITS+1)'({1'b0, {(WORD_BITS-1){1'b1}}})))
      return {1'b0, {(WORD_BITS-1){1'b1}}};
    if (v < -$signed((T_BITS+1)'({1'b1, {(WORD_BITS-1){1'b0}}})))
      return {1'b1, {(WORD_BITS-1){1'b0}}};
    return v[WORD_BITS-1:0];
  endfunction

endpackage

[sv/radix2_complex_fft_core.sv]
// radix2_complex_fft_core: top level of the in-place radix-2 dit fft
// joins the sequencer fftc_ctrl and the datapath fftc_datapath; uses fftc_pkg
//
// usage
//   command channel: start with busy low is one transfer; in_opcode load
//   writes the next sample at its bit-reversed address, read fetches a bin
//   a load gives no result; the load that completes a frame starts the
//   transform and busy stays high while it runs, including the divide-by-n
//   scaling pass in inverse mode (each butterfly reads p and k, multiplies,
//   sums and writes k and p through the sample memory)
//   a read returns its bin with out_valid in the cycle after the transfer, and
//   reads may follow back to back; out_valid lasts one cycle, the receiver
//   cannot stall it
//   config channel: cfg_valid with cfg_ready is one transfer, index 0 sets
//   log2_points (restarts the frame), index 1 sets inverse_mode; cfg_ready
//   is low while a transform runs
//   reset: length 1024, forward mode, frame counter and done flag cleared;
//   sample memory contents are undefined until written
module radix2_complex_fft_core (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  output logic                                      busy,
  input  logic                                      in_opcode,
  input  logic signed [fftc_pkg::SAMPLE_BITS-1:0]   in_sample_real,
  input  logic signed [fftc_pkg::SAMPLE_BITS-1:0]   in_sample_imag,
  input  logic [fftc_pkg::AW-1:0]                   in_bin_index,
  output logic                                      out_valid,
  output logic signed [fftc_pkg::WORD_BITS-1:0]     out_bin_real,
  output logic signed [fftc_pkg::WORD_BITS-1:0]     out_bin_imag,
  output logic                                      out_transform_done,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [fftc_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [fftc_pkg::CFG_DATA_W-1:0]           cfg_wdata
);
  import fftc_pkg::*;

  // command word from sequencer to datapath
  dp_cmd_t cmd;

  // sequencer: config registers, frame count, butterfly and scaling walk
  fftc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_opcode    (in_opcode),
    .in_bin_index (in_bin_index),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cfg_ready    (cfg_ready),
    .busy         (busy),
    .cmd          (cmd)
  );

  // datapath: sample memory, twiddles, multipliers, result register
  fftc_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_sample_real     (in_sample_real),
    .in_sample_imag     (in_sample_imag),
    .out_valid          (out_valid),
    .out_bin_real       (out_bin_real),
    .out_bin_imag       (out_bin_imag),
    .out_transform_done (out_transform_done)
  );

endmodule

[sv/fftc_ctrl.sv]
// fftc_ctrl: sequencer of the fft core, holds configuration, frame counters
// and walks butterflies and the inverse scaling pass; depends on fftc_pkg
module fftc_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                in_opcode,
  input  logic [fftc_pkg::AW-1:0]             in_bin_index,
  input  logic                                cfg_valid,
  input  logic [fftc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fftc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                cfg_ready,
  output logic                                busy,
  output fftc_pkg::dp_cmd_t                   cmd
);
  import fftc_pkg::*;

  st_t                  state_r, state_nxt;
  logic [LOG_W-1:0]     log2_r, log2_nxt;
  logic                 inv_r, inv_nxt;
  logic [AW-1:0]        cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [LOG_W-1:0]     stage_r, stage_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [LOG_W-1:0]     l_eff;
  logic [AW-1:0]        n_mask, half_last, cnt_m;
  logic                 accept;

  always_comb begin
    if (log2_r < LOG_W'(1))                    l_eff = LOG_W'(1);
    else if (log2_r > LOG_W'(MAX_LOG2_POINTS)) l_eff = LOG_W'(MAX_LOG2_POINTS);
    else                                       l_eff = log2_r;
  end

  assign n_mask    = AW'(({{AW{1'b0}}, 1'b1} << l_eff) - 1'b1);
  assign half_last = n_mask >> 1;
  assign cnt_m     = cnt_r & n_mask;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      log2_r  <= LOG_W'(MAX_LOG2_POINTS);
      inv_r   <= 1'b0;
      cnt_r   <= '0;
      done_r  <= 1'b0;
      stage_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      log2_r  <= log2_nxt;
      inv_r   <= inv_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      stage_r <= stage_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    log2_nxt    = log2_r;
    inv_nxt     = inv_r;
    cnt_nxt     = cnt_r;
    done_nxt    = done_r;
    stage_nxt   = stage_r;
    idx_nxt     = idx_r;
    cmd.op      = OP_NOP;
    cmd.l       = l_eff;
    cmd.stage   = stage_r;
    cmd.idx     = idx_r;
    cmd.inverse = inv_r;
    cmd.done    = done_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOG2_POINTS: begin
          log2_nxt = cfg_wdata[LOG_W-1:0];
          cnt_nxt  = '0;
        end
        CFG_INVERSE_MODE: inv_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OPC_LOAD) begin
            cmd.op   = OP_LOAD;
            cmd.idx  = bit_rev(cnt_m, l_eff);
            done_nxt = 1'b0;
            if (cnt_m == n_mask) begin
              cnt_nxt   = '0;
              stage_nxt = LOG_W'(1);
              idx_nxt   = '0;
              state_nxt = ST_RDP;
            end else begin
              cnt_nxt = cnt_m + 1'b1;
            end
          end else begin
            cmd.op  = OP_READ;
            cmd.idx = in_bin_index & n_mask;
          end
        end
      end
      ST_RDP: begin cmd.op = OP_RDP; state_nxt = ST_RDK; end
      ST_RDK: begin cmd.op = OP_RDK; state_nxt = ST_MUL; end
      ST_MUL: begin cmd.op = OP_MUL; state_nxt = ST_SUM; end
      ST_SUM: begin cmd.op = OP_SUM; state_nxt = ST_WRK; end
      ST_WRK: begin cmd.op = OP_WRK; state_nxt = ST_WRP; end
      ST_WRP: begin
        cmd.op = OP_WRP;
        if (idx_r == half_last) begin
          idx_nxt = '0;
          if (stage_r == l_eff) begin
            if (inv_r) begin
              state_nxt = ST_SC_RD;
            end else begin
              state_nxt = ST_IDLE;
              done_nxt  = 1'b1;
            end
          end else begin
            stage_nxt = stage_r + 1'b1;
            state_nxt = ST_RDP;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_RDP;
        end
      end
      ST_SC_RD: begin cmd.op = OP_SC_RD; state_nxt = ST_SC_WR; end
      ST_SC_WR: begin
        cmd.op = OP_SC_WR;
        if (idx_r == n_mask) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
          done_nxt  = 1'b1;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SC_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[sv/fftc_datapath.sv]
// fftc_datapath: sample memory, twiddle lookup and butterfly arithmetic
// driven by command words from fftc_ctrl; depends on fftc_pkg
module fftc_datapath (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  fftc_pkg::dp_cmd_t                         cmd,
  input  logic signed [fftc_pkg::SAMPLE_BITS-1:0]   in_sample_real,
  input  logic signed [fftc_pkg::SAMPLE_BITS-1:0]   in_sample_imag,
  output logic                                      out_valid,
  output logic signed [fftc_pkg::WORD_BITS-1:0]     out_bin_real,
  output logic signed [fftc_pkg::WORD_BITS-1:0]     out_bin_imag,
  output logic                                      out_transform_done
);
  import fftc_pkg::*;

  logic [2*WORD_BITS-1:0] mem [FULL_N];
  logic [2*WORD_BITS-1:0] rd_data_r, wdata;
  logic [AW-1:0]          raddr, waddr, hmask, k_addr, p_addr, hbit;
  logic [AW-1:0]          tw_full;
  logic                   ren, wen;
  logic signed [TW_BITS-1:0]   wc_r, ws_r, ws_sel;
  word_t                  br_r, bi_r, ur_r, ui_r;
  logic signed [PROD_BITS-1:0] prr_r, pii_r, pri_r, pir_r;
  word_t                  sr_r, si_r, dr_r, di_r;
  logic signed [PROD_BITS+1:0] acc_r, acc_i;
  logic signed [T_BITS-1:0]    tr, ti;
  logic signed [T_BITS:0]      ur_x, ui_x;
  word_t                  rd_re, rd_im;
  logic                   valid_r, done_r;

  assign hbit    = AW'({{AW{1'b0}}, 1'b1} << (cmd.stage - 1'b1));
  assign hmask   = hbit - 1'b1;
  assign k_addr  = ((cmd.idx >> (cmd.stage - 1'b1)) << cmd.stage) | (cmd.idx & hmask);
  assign p_addr  = k_addr | hbit;
  assign tw_full = (cmd.idx & hmask) << (LOG_W'(MAX_LOG2_POINTS) - cmd.stage);
  assign ws_sel  = cmd.inverse ? TW_SIN[tw_full[TW_AW-1:0]] : -TW_SIN[tw_full[TW_AW-1:0]];

  assign rd_re = rd_data_r[2*WORD_BITS-1:WORD_BITS];
  assign rd_im = rd_data_r[WORD_BITS-1:0];

  // rounded products, half up to integer
  assign acc_r = (PROD_BITS+2)'(prr_r) - (PROD_BITS+2)'(pii_r) + (PROD_BITS+2)'(1 <<< 14);
  assign acc_i = (PROD_BITS+2)'(pri_r) + (PROD_BITS+2)'(pir_r) + (PROD_BITS+2)'(1 <<< 14);
  assign tr    = T_BITS'(acc_r >>> 15);
  assign ti    = T_BITS'(acc_i >>> 15);
  assign ur_x  = (T_BITS+1)'(ur_r);
  assign ui_x  = (T_BITS+1)'(ui_r);

  always_comb begin
    ren   = 1'b0;
    wen   = 1'b0;
    raddr = cmd.idx;
    waddr = cmd.idx;
    wdata = {WORD_BITS'(in_sample_real), WORD_BITS'(in_sample_imag)};
    unique case (cmd.op)
      OP_LOAD:  wen = 1'b1;
      OP_READ:  ren = 1'b1;
      OP_RDP:   begin ren = 1'b1; raddr = p_addr; end
      OP_RDK:   begin ren = 1'b1; raddr = k_addr; end
      OP_WRK:   begin wen = 1'b1; waddr = k_addr; wdata = {sr_r, si_r}; end
      OP_WRP:   begin wen = 1'b1; waddr = p_addr; wdata = {dr_r, di_r}; end
      OP_SC_RD: ren = 1'b1;
      OP_SC_WR: begin
        wen   = 1'b1;
        wdata = {word_t'(rd_re >>> cmd.l), word_t'(rd_im >>> cmd.l)};
      end
      OP_NOP, OP_MUL, OP_SUM: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ren) rd_data_r <= mem[raddr];
    if (wen) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RDP) begin
      wc_r <= TW_COS[tw_full[TW_AW-1:0]];
      ws_r <= ws_sel;
    end
    if (cmd.op == OP_RDK) begin
      br_r <= rd_re;
      bi_r <= rd_im;
    end
    if (cmd.op == OP_MUL) begin
      ur_r  <= rd_re;
      ui_r  <= rd_im;
      prr_r <= br_r * wc_r;
      pii_r <= bi_r * ws_r;
      pri_r <= br_r * ws_r;
      pir_r <= bi_r * wc_r;
    end
    if (cmd.op == OP_SUM) begin
      sr_r <= sat_word(ur_x + (T_BITS+1)'(tr));
      si_r <= sat_word(ui_x + (T_BITS+1)'(ti));
      dr_r <= sat_word(ur_x - (T_BITS+1)'(tr));
      di_r <= sat_word(ui_x - (T_BITS+1)'(ti));
    end
    if (cmd.op == OP_READ) done_r <= cmd.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= (cmd.op == OP_READ);
  end

  assign out_valid          = valid_r;
  assign out_bin_real       = rd_re;
  assign out_bin_imag       = rd_im;
  assign out_transform_done = done_r;

endmodule

[test/radix2_complex_fft_core_checker.sv]
// radix2_complex_fft_core_checker: transfer monitor, bin predictor and compare for the fft core
// predicts bins from its own copy of the sample store, twiddle rom and registers
// depends on fftc_pkg
module radix2_complex_fft_core_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic                                    busy,
  input  logic                                    in_opcode,
  input  logic signed [fftc_pkg::SAMPLE_BITS-1:0] in_sample_real,
  input  logic signed [fftc_pkg::SAMPLE_BITS-1:0] in_sample_imag,
  input  logic [fftc_pkg::AW-1:0]                 in_bin_index,
  input  logic                                    out_valid,
  input  logic signed [fftc_pkg::WORD_BITS-1:0]   out_bin_real,
  input  logic signed [fftc_pkg::WORD_BITS-1:0]   out_bin_imag,
  input  logic                                    out_transform_done,
  input  logic                                    cfg_valid,
  input  logic                                    cfg_ready,
  input  logic [fftc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [fftc_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  output int                                      mismatches,
  output int                                      pending
);
  import fftc_pkg::*;

  typedef struct {
    word_t re;
    word_t im;
    logic  done;
  } bin_t;

  localparam longint WORD_MAX = (64'sd1 <<< (WORD_BITS - 1)) - 1;
  localparam longint WORD_MIN = -(64'sd1 <<< (WORD_BITS - 1));

  longint cos_rom [FULL_N/2];
  longint sin_rom [FULL_N/2];
  longint store_re [FULL_N];
  longint store_im [FULL_N];
  int     fill_count;
  logic   frame_ready;
  int     reg_log2;
  logic   reg_inverse;
  bin_t   bin_queue [$];

  function automatic longint q30_to_q15(input longint v);
    longint r;
    r = (v < 0) ? 0 : v;
    r = (r + (1 << 14)) >>> 15;
    return (r > 32767) ? 32767 : r;
  endfunction

  // sine and cosine by taylor series in q30, second quadrant mirrored
  task automatic build_twiddle_rom();
    longint unsigned ang, term, kk;
    longint sn, cs;
    bit flip;
    for (int k = 0; k < FULL_N / 2; k++) begin
      kk = k;
      flip = (4 * k > FULL_N);
      if (flip) kk = FULL_N / 2 - k;
      ang = (2 * PI_Q30 * kk + (64'd1 << (MAX_LOG2_POINTS - 1))) >> MAX_LOG2_POINTS;
      term = ang;
      sn = ang;
      for (int i = 1; i <= 6; i++) begin
        term = ((((term * ang) >> 30) * ang) >> 30) / ((2 * i) * (2 * i + 1));
        if (i % 2) sn -= term; else sn += term;
      end
      term = ONE_Q30;
      cs = ONE_Q30;
      for (int i = 1; i <= 7; i++) begin
        term = ((((term * ang) >> 30) * ang) >> 30) / ((2 * i - 1) * (2 * i));
        if (i % 2) cs -= term; else cs += term;
      end
      cos_rom[k] = flip ? -q30_to_q15(cs) : q30_to_q15(cs);
      sin_rom[k] = q30_to_q15(sn);
    end
  endtask

  function automatic longint clip_word(input longint v);
    return (v > WORD_MAX) ? WORD_MAX : ((v < WORD_MIN) ? WORD_MIN : v);
  endfunction

  function automatic int eff_log2();
    return (reg_log2 < 1) ? 1 : ((reg_log2 > MAX_LOG2_POINTS) ? MAX_LOG2_POINTS : reg_log2);
  endfunction

  function automatic int reverse_addr(input int v, input int bits);
    int r;
    r = 0;
    for (int i = 0; i < bits; i++) r = (r << 1) | ((v >> i) & 1);
    return r;
  endfunction

  // in-place decimation in time over the first 2^l words
  task automatic run_butterflies(input int l);
    int h, tix, p;
    longint wc, ws, br, bi, tr, ti, ur, ui;
    for (int s = 1; s <= l; s++) begin
      h = 1 << (s - 1);
      for (int j = 0; j < h; j++) begin
        tix = (j << (MAX_LOG2_POINTS - s)) & (FULL_N / 2 - 1);
        wc = cos_rom[tix];
        ws = reg_inverse ? sin_rom[tix] : -sin_rom[tix];
        for (int k = j; k + h < (1 << l); k += 2 * h) begin
          p = k + h;
          br = store_re[p];
          bi = store_im[p];
          tr = (br * wc - bi * ws + (1 << 14)) >>> 15;
          ti = (br * ws + bi * wc + (1 << 14)) >>> 15;
          ur = store_re[k];
          ui = store_im[k];
          store_re[k] = clip_word(ur + tr);
          store_im[k] = clip_word(ui + ti);
          store_re[p] = clip_word(ur - tr);
          store_im[p] = clip_word(ui - ti);
        end
      end
    end
    if (reg_inverse) begin
      for (int i = 0; i < (1 << l); i++) begin
        store_re[i] = store_re[i] >>> l;
        store_im[i] = store_im[i] >>> l;
      end
    end
  endtask

  task automatic load_sample(input longint re, input longint im);
    int l, n, addr;
    l = eff_log2();
    n = 1 << l;
    addr = reverse_addr(fill_count & (n - 1), l);
    store_re[addr] = re;
    store_im[addr] = im;
    frame_ready = 1'b0;
    fill_count = (fill_count & (n - 1)) + 1;
    if (fill_count >= n) begin
      run_butterflies(l);
      fill_count = 0;
      frame_ready = 1'b1;
    end
  endtask

  task automatic compare_bin();
    bin_t want;
    if (bin_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected bin: re %0d im %0d done %0b",
                 out_bin_real, out_bin_imag, out_transform_done);
      return;
    end
    want = bin_queue.pop_front();
    if (out_bin_real !== want.re || out_bin_imag !== want.im ||
        out_transform_done !== want.done) begin
      mismatches++;
      if (mismatches <= 10)
        $display("bin mismatch: expected re %0d im %0d done %0b, got re %0d im %0d done %0b",
                 want.re, want.im, want.done, out_bin_real, out_bin_imag, out_transform_done);
    end
  endtask

  initial begin
    build_twiddle_rom();
  end

  always @(posedge clk) begin
    bin_t b;
    int n;
    if (!rst_n) begin
      mismatches = 0;
      fill_count = 0;
      frame_ready = 1'b0;
      reg_log2 = 10;
      reg_inverse = 1'b0;
      bin_queue.delete();
      pending <= 0;
    end else begin
      if (out_valid) compare_bin();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LOG2_POINTS) begin
          reg_log2 = cfg_wdata;
          fill_count = 0;
        end else if (cfg_index == CFG_INVERSE_MODE) begin
          reg_inverse = cfg_wdata[0];
        end
      end
      if (start && !busy) begin
        if (in_opcode == OPC_LOAD) begin
          load_sample(in_sample_real, in_sample_imag);
        end else begin
          n = 1 << eff_log2();
          b.re = word_t'(store_re[in_bin_index & (n - 1)]);
          b.im = word_t'(store_im[in_bin_index & (n - 1)]);
          b.done = frame_ready;
          bin_queue = {bin_queue, b};
        end
      end
      pending <= bin_queue.size();
    end
  end

endmodule

[test/radix2_complex_fft_core_tb.sv]
// radix2_complex_fft_core_tb: stimulus and verdict for the radix-2 fft core
// drives commands and register writes, the checker predicts and compares bins
// depends on fftc_pkg, radix2_complex_fft_core and radix2_complex_fft_core_checker
module radix2_complex_fft_core_tb;
  import fftc_pkg::*;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic                          in_opcode;
  logic signed [SAMPLE_BITS-1:0] in_sample_real;
  logic signed [SAMPLE_BITS-1:0] in_sample_imag;
  logic [AW-1:0]                 in_bin_index;
  logic                          out_valid;
  logic signed [WORD_BITS-1:0]   out_bin_real;
  logic signed [WORD_BITS-1:0]   out_bin_imag;
  logic                          out_transform_done;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_wdata;
  int                            mismatches;
  int                            pending;

  // stimulus-side view of the store: which words hold a loaded sample
  bit written [FULL_N];
  int cur_log2;
  int load_cnt;
  int idle_pct;
  int item_count;

  radix2_complex_fft_core dut (.*);
  radix2_complex_fft_core_checker checker_i (.*);

  always #4 clk = ~clk;

  function automatic int reverse_addr(input int v, input int bits);
    int r;
    r = 0;
    for (int i = 0; i < bits; i++) r = (r << 1) | ((v >> i) & 1);
    return r;
  endfunction

  // one command transfer; start stays high unless an idle gap is drawn
  task automatic issue(input logic op, input int re, input int im, input int bin);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_sample_real <= SAMPLE_BITS'(re);
    in_sample_imag <= SAMPLE_BITS'(im);
    in_bin_index   <= AW'(bin);
    @(posedge clk);
    while (busy) @(posedge clk);
    item_count++;
    if (op == OPC_LOAD) begin
      written[reverse_addr(load_cnt, cur_log2)] = 1'b1;
      load_cnt++;
      if (load_cnt == (1 << cur_log2)) load_cnt = 0;
    end
  endtask

  task automatic load_sample(input int re, input int im);
    issue(OPC_LOAD, re, im, $urandom_range(1023));
  endtask

  task automatic load_random();
    load_sample($urandom_range(65535), $urandom_range(65535));
  endtask

  // read a random bin that holds data; fall back to a load if none is found
  task automatic read_random();
    int bin;
    for (int t = 0; t < 8; t++) begin
      bin = $urandom_range(1023);
      if (written[bin & ((1 << cur_log2) - 1)]) begin
        issue(OPC_READ, $urandom_range(65535), $urandom_range(65535), bin);
        return;
      end
    end
    load_random();
  endtask

  // register write transfer; the caller lowers cfg_valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_LOG2_POINTS) begin
      cur_log2 = (val < 1) ? 1 : ((val > MAX_LOG2_POINTS) ? MAX_LOG2_POINTS : val);
      load_cnt = 0;
    end
  endtask

  // stop sending and let every outstanding bin arrive
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input int l, input int inv);
    drain();
    write_reg(CFG_LOG2_POINTS, l);
    write_reg(CFG_INVERSE_MODE, inv);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int l, n, phase, frames;
    int idle_by_phase [4];
    idle_by_phase = '{0, 74, 0, 27};
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OPC_LOAD;
    in_sample_real = '0;
    in_sample_imag = '0;
    in_bin_index = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cur_log2 = MAX_LOG2_POINTS;
    load_cnt = 0;
    idle_pct = 0;
    item_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two-point frame of full-scale extremes, reads wrap modulo the length
    set_regs(1, 0);
    load_sample(32767, -32768);
    load_sample(-32768, 32767);
    issue(OPC_READ, 0, 0, 0);
    issue(OPC_READ, 0, 0, 1023);
    issue(OPC_READ, 0, 0, 2);
    // a load clears the done flag
    load_sample(0, 0);
    issue(OPC_READ, 0, 0, 0);
    // mode flipped mid-frame takes effect at the transform
    drain();
    write_reg(CFG_INVERSE_MODE, 1);
    cfg_valid <= 1'b0;
    load_sample(-1, -1);
    issue(OPC_READ, 0, 0, 0);
    issue(OPC_READ, 0, 0, 1);
    // zero length clamps to two points
    set_regs(0, 1);
    load_sample(-32768, -32768);
    load_sample(-32768, -32768);
    issue(OPC_READ, 0, 0, 1);
    // four points forward, all extremes
    set_regs(2, 0);
    load_sample(32767, 32767);
    load_sample(-32768, 32767);
    load_sample(32767, -32768);
    load_sample(-32768, -32768);
    for (int b = 0; b < 4; b++) issue(OPC_READ, 0, 0, b);
    // oversized length clamps to full size; partial frame then a restart
    set_regs(15, 0);
    load_sample(1234, -4321);
    load_sample(-7, 7);
    issue(OPC_READ, 0, 0, 512);

    // random phases: mostly whole frames with reads mixed in, one long frame
    phase = 0;
    while (item_count < 900) begin
      if (phase == 4) l = 9;
      else if ($urandom_range(99) < 65) l = $urandom_range(1, 4);
      else if ($urandom_range(99) < 80) l = $urandom_range(5, 7);
      else l = $urandom_range(1) ? 0 : 8;
      if (phase % 3 == 2) begin
        // only the mode changes, frame position carries over
        drain();
        write_reg(CFG_INVERSE_MODE, $urandom_range(1));
        cfg_valid <= 1'b0;
      end else begin
        set_regs(l, $urandom_range(1));
      end
      idle_pct = idle_by_phase[phase % 4];
      n = 1 << cur_log2;
      frames = (phase == 4) ? 1 : $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        for (int i = 0; i < n; i++) begin
          if (phase != 4 && $urandom_range(99) < 25) read_random();
          load_random();
        end
        for (int r = $urandom_range(1, 6); r > 0; r--) read_random();
      end
      // sometimes leave a partial frame for the next register write
      if (phase != 4 && $urandom_range(99) < 30)
        for (int i = $urandom_range(1, n); i > 0; i--) load_random();
      for (int r = $urandom_range(1, 4); r > 0; r--) read_random();
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("radix2_complex_fft_core_tb: done, clean");
    end else begin
      $display("radix2_complex_fft_core_tb: done, errors");
    end
    $finish;
  end

  // hard limit well beyond the slowest legal run
  initial begin
    #8000000;
    $display("radix2_complex_fft_core_tb: done, errors");
    $finish;
  end

endmodule

[radix2_complex_fft_core.f]
sv/fftc_pkg.sv
sv/fftc_ctrl.sv
sv/fftc_datapath.sv
sv/radix2_complex_fft_core.sv
test/radix2_complex_fft_core_checker.sv
test/radix2_complex_fft_core_tb.sv
